### src/krq_pkg.sv
// Package for the keyed response queue: mode codes, entry type and depth default.
`default_nettype none
package krq_pkg;
  localparam int QueueDepthDef = 8;

  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_FIND  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic [15:0] cmd;
    logic [15:0] status;
    logic [15:0] length;
    logic [31:0] pref;
    logic [31:0] stamp;
  } entry_t;
endpackage
`default_nettype wire

### src/keyed_response_queue.sv
// Keyed response queue: ring of response entries in one synchronous memory.
//
// Usage: items arrive on the in_ channel (valid/ready) with a mode of push,
// find-pop or clear. Every accepted item yields exactly one result item on the
// out_ channel (valid/ready) carrying found, dropped_oldest, the removed
// entry's fields (zero unless found) and the occupancy after the operation.
// Push, clear and the unused mode go from acceptance through ST_DONE to the result.
// Find-pop reads the entries one per cycle from oldest to newest through the
// single memory read port; on a match it compacts the later entries, one
// read and one write-back per cycle. The entries scanned plus the entries
// moved never exceed the fill count.
// One item is in work at a time; the result sits in an output register, and
// the next item is taken only once the result leaves, at the earliest in the
// same cycle. A stalled receiver holds the result steady and blocks the input.
// Reset empties the queue (head, tail and count cleared) and drops any item
// in work; memory contents stay undefined until written.
`default_nettype none
module keyed_response_queue #(
  parameter int QUEUE_DEPTH = krq_pkg::QueueDepthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [15:0] in_cmd_key,
  input  wire logic [15:0] in_entry_status,
  input  wire logic [15:0] in_entry_length,
  input  wire logic [31:0] in_payload_ref,
  input  wire logic [31:0] in_arrival_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_found,
  output logic             out_dropped_oldest,
  output logic [15:0]      out_cmd,
  output logic [15:0]      out_status,
  output logic [15:0]      out_length,
  output logic [31:0]      out_payload_ref,
  output logic [31:0]      out_time,
  output logic [3:0]       out_occupancy
);
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;   // read issued, compare next cycle
  localparam logic [2:0] ST_MOVE = 3'd2;   // read of later entry issued
  localparam logic [2:0] ST_DONE = 3'd3;   // result register loaded, raise valid

  // Memory
  krq_pkg::entry_t mem [QUEUE_DEPTH];
  krq_pkg::entry_t rd_data_r;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  krq_pkg::entry_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // Control
  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] pos_r, pos_nxt;       // offset from head of pending read
  logic [AW-1:0] addr_r, addr_nxt;     // address of pending read
  logic [15:0]   key_r, key_nxt;
  logic          res_vld_r, res_vld_nxt;
  logic          found_r, found_nxt, drop_r, drop_nxt;
  krq_pkg::entry_t res_r, res_nxt;
  logic [3:0]    occ_r, occ_nxt;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] a);
    return (a == LAST_IDX) ? '0 : a + AW'(1);
  endfunction
  function automatic logic [AW-1:0] dec(input logic [AW-1:0] a);
    return (a == '0) ? LAST_IDX : a - AW'(1);
  endfunction

  wire take = out_valid && out_ready;
  assign in_ready = (state_r == ST_IDLE) && (!res_vld_r || out_ready);
  wire acc = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    head_nxt = head_r; tail_nxt = tail_r; count_nxt = count_r;
    pos_nxt = pos_r; addr_nxt = addr_r; key_nxt = key_r;
    res_vld_nxt = res_vld_r && !take;
    found_nxt = found_r; drop_nxt = drop_r; res_nxt = res_r; occ_nxt = occ_r;
    rd_en = 1'b0; rd_addr = addr_r;
    wr_en = 1'b0; wr_addr = tail_r;
    wr_data = '{cmd: in_cmd_key, status: in_entry_status, length: in_entry_length,
                pref: in_payload_ref, stamp: in_arrival_time};
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          found_nxt = 1'b0; drop_nxt = 1'b0; res_nxt = '0;
          state_nxt = ST_DONE;
          case (in_mode)
            krq_pkg::MODE_PUSH: begin
              wr_en = 1'b1;
              tail_nxt = inc(tail_r);
              if (count_r == DEPTH_C) begin
                head_nxt = inc(head_r);
                drop_nxt = 1'b1;
              end else begin
                count_nxt = count_r + CW'(1);
              end
            end
            krq_pkg::MODE_FIND: begin
              key_nxt = in_cmd_key;
              if (count_r != '0) begin
                rd_en = 1'b1; rd_addr = head_r;
                addr_nxt = head_r; pos_nxt = '0;
                state_nxt = ST_SCAN;
              end
            end
            krq_pkg::MODE_CLEAR: begin
              head_nxt = '0; tail_nxt = '0; count_nxt = '0;
            end
            default: ;
          endcase
          occ_nxt = 4'(count_nxt);
        end
      end
      ST_SCAN: begin
        if (rd_data_r.cmd == key_r) begin
          found_nxt = 1'b1; res_nxt = rd_data_r;
          if (pos_r + CW'(1) < count_r) begin
            // hold addr_r as hole, read next
            rd_en = 1'b1; rd_addr = inc(addr_r);
            state_nxt = ST_MOVE;
          end else begin
            count_nxt = count_r - CW'(1); tail_nxt = dec(tail_r);
            occ_nxt = 4'(count_nxt); state_nxt = ST_DONE;
          end
        end else if (pos_r + CW'(1) < count_r) begin
          rd_en = 1'b1; rd_addr = inc(addr_r);
          addr_nxt = inc(addr_r); pos_nxt = pos_r + CW'(1);
        end else begin
          occ_nxt = 4'(count_r); state_nxt = ST_DONE;
        end
      end
      ST_MOVE: begin
        // write read entry into the hole, advance hole
        wr_en = 1'b1; wr_addr = addr_r; wr_data = rd_data_r;
        addr_nxt = inc(addr_r); pos_nxt = pos_r + CW'(1);
        if (pos_r + CW'(2) < count_r) begin
          rd_en = 1'b1; rd_addr = inc(inc(addr_r));
        end else begin
          count_nxt = count_r - CW'(1); tail_nxt = dec(tail_r);
          occ_nxt = 4'(count_nxt); state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        res_vld_nxt = 1'b1; state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; head_r <= '0; tail_r <= '0; count_r <= '0;
      res_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt; head_r <= head_nxt; tail_r <= tail_nxt;
      count_r <= count_nxt; res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt; addr_r <= addr_nxt; key_r <= key_nxt;
    found_r <= found_nxt; drop_r <= drop_nxt; res_r <= res_nxt; occ_r <= occ_nxt;
  end

  assign out_valid          = res_vld_r;
  assign out_found          = found_r;
  assign out_dropped_oldest = drop_r;
  assign out_cmd            = res_r.cmd;
  assign out_status         = res_r.status;
  assign out_length         = res_r.length;
  assign out_payload_ref    = res_r.pref;
  assign out_time           = res_r.stamp;
  assign out_occupancy      = occ_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C) else $error("fill count above depth");
  a_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == DEPTH_C || count_r == '0) |-> (head_r == tail_r))
    else $error("head and tail disagree with count");
  a_no_drop_find: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && out_dropped_oldest))
    else $error("found and dropped together");
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready) else $error("ready while busy");
endmodule
`default_nettype wire

### tb/tb_top.sv
// Testbench for the keyed response queue: scoreboarded push, find-pop and clear traffic.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  localparam int Depth      = 8;
  localparam int StallLimit = 2000;
  localparam logic [1:0] ModeUnused = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_mode;
  logic [15:0] in_cmd_key;
  logic [15:0] in_entry_status;
  logic [15:0] in_entry_length;
  logic [31:0] in_payload_ref;
  logic [31:0] in_arrival_time;
  logic        out_valid;
  logic        out_ready;
  logic        out_found;
  logic        out_dropped_oldest;
  logic [15:0] out_cmd;
  logic [15:0] out_status;
  logic [15:0] out_length;
  logic [31:0] out_payload_ref;
  logic [31:0] out_time;
  logic [3:0]  out_occupancy;

  // One expected result item.
  typedef struct packed {
    logic            found;
    logic            dropped;
    krq_pkg::entry_t ent;
    logic [3:0]      occ;
  } response_t;

  keyed_response_queue #(.QUEUE_DEPTH(Depth)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_cmd_key(in_cmd_key),
    .in_entry_status(in_entry_status), .in_entry_length(in_entry_length),
    .in_payload_ref(in_payload_ref), .in_arrival_time(in_arrival_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_found(out_found), .out_dropped_oldest(out_dropped_oldest),
    .out_cmd(out_cmd), .out_status(out_status), .out_length(out_length),
    .out_payload_ref(out_payload_ref), .out_time(out_time),
    .out_occupancy(out_occupancy)
  );

  // Shadow of the queue, kept oldest first; the ring pointers are invisible outside.
  krq_pkg::entry_t shadow_q[$];
  response_t       pending_q[$];
  int              fail_count;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advance the shadow by one item and return the result it should produce.
  function automatic response_t queue_predict(logic [1:0] mode, krq_pkg::entry_t ent);
    response_t r;
    r = '0;
    if (mode == krq_pkg::MODE_PUSH) begin
      if (shadow_q.size() >= Depth) begin
        void'(shadow_q.pop_front());
        r.dropped = 1'b1;
      end
      shadow_q.push_back(ent);
    end else if (mode == krq_pkg::MODE_FIND) begin
      for (int i = 0; i < shadow_q.size(); i++) begin
        if (shadow_q[i].cmd == ent.cmd) begin
          r.found = 1'b1;
          r.ent = shadow_q[i];
          shadow_q.delete(i);
          break;
        end
      end
    end else if (mode == krq_pkg::MODE_CLEAR) begin
      shadow_q.delete();
    end
    r.occ = 4'(shadow_q.size());
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Offer one item, hold it until taken, and predict its result on acceptance.
  // Valid stays high into the next item unless the sender idles.
  task automatic send_item(logic [1:0] mode, krq_pkg::entry_t ent);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_cmd_key      <= ent.cmd;
    in_entry_status <= ent.status;
    in_entry_length <= ent.length;
    in_payload_ref  <= ent.pref;
    in_arrival_time <= ent.stamp;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(queue_predict(mode, ent));
  endtask

  function automatic krq_pkg::entry_t rand_entry(logic [15:0] key);
    krq_pkg::entry_t e;
    e.cmd    = key;
    e.status = 16'($urandom);
    e.length = 16'($urandom);
    e.pref   = $urandom;
    e.stamp  = $urandom;
    return e;
  endfunction

  // Keys drawn from a narrow set so finds hit often; sometimes any key.
  function automatic logic [15:0] rand_key();
    return ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(5));
  endfunction

  // Drop valid and wait until every expected result has come.
  task automatic drain_pending();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_field_extremes();
    send_item(krq_pkg::MODE_PUSH,
              '{16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_item(krq_pkg::MODE_PUSH, '0);
    send_item(krq_pkg::MODE_FIND, '{16'hFFFF, 16'h0, 16'h0, 32'h0, 32'h0});
    send_item(krq_pkg::MODE_FIND, '0);
    send_item(krq_pkg::MODE_FIND, '0);             // find on an empty queue
    send_item(ModeUnused, rand_entry(16'h1));      // unused mode is ignored
  endtask

  task automatic test_fill_and_drop();
    for (int i = 0; i < Depth + 3; i++) send_item(krq_pkg::MODE_PUSH, rand_entry(16'(i)));
    send_item(krq_pkg::MODE_FIND, rand_entry(16'h5));   // middle entry, later ones close up
    send_item(krq_pkg::MODE_FIND, rand_entry(16'h1234)); // no match
    send_item(krq_pkg::MODE_FIND, rand_entry(16'(Depth + 2))); // newest
    send_item(krq_pkg::MODE_FIND, rand_entry(16'h3));   // oldest
    send_item(krq_pkg::MODE_PUSH, rand_entry(16'h7));   // duplicate key, first one wins
    send_item(krq_pkg::MODE_FIND, rand_entry(16'h7));
    send_item(krq_pkg::MODE_CLEAR, rand_entry(16'h0));
    send_item(krq_pkg::MODE_FIND, rand_entry(16'h7));
  endtask

  task automatic test_random_traffic(int count);
    int m;
    for (int i = 0; i < count; i++) begin
      m = $urandom_range(99);
      if (m < 50)      send_item(krq_pkg::MODE_PUSH, rand_entry(rand_key()));
      else if (m < 92) send_item(krq_pkg::MODE_FIND, rand_entry(rand_key()));
      else if (m < 97) send_item(krq_pkg::MODE_CLEAR, rand_entry(rand_key()));
      else             send_item(ModeUnused, rand_entry(rand_key()));
    end
  endtask

  // Receiver: stall at random, check every result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          $display("unexpected result item at %0t", $realtime);
          fail_count++;
        end else begin
          response_t w;
          w = pending_q.pop_front();
          if (out_found !== w.found)
            report_mismatch("found", 32'(out_found), 32'(w.found));
          if (out_dropped_oldest !== w.dropped)
            report_mismatch("dropped_oldest", 32'(out_dropped_oldest), 32'(w.dropped));
          if (out_cmd !== w.ent.cmd)
            report_mismatch("cmd", 32'(out_cmd), 32'(w.ent.cmd));
          if (out_status !== w.ent.status)
            report_mismatch("status", 32'(out_status), 32'(w.ent.status));
          if (out_length !== w.ent.length)
            report_mismatch("length", 32'(out_length), 32'(w.ent.length));
          if (out_payload_ref !== w.ent.pref)
            report_mismatch("payload_ref", out_payload_ref, w.ent.pref);
          if (out_time !== w.ent.stamp) report_mismatch("time", out_time, w.ent.stamp);
          if (out_occupancy !== w.occ)
            report_mismatch("occupancy", 32'(out_occupancy), 32'(w.occ));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    fail_count      = 0;
    quiet_cycles    = 0;
    send_idle_pct   = 19;
    recv_idle_pct   = 64;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_mode         = krq_pkg::MODE_PUSH;
    in_cmd_key      = '0;
    in_entry_status = '0;
    in_entry_length = '0;
    in_payload_ref  = '0;
    in_arrival_time = '0;
    out_ready       = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_fill_and_drop();
    test_random_traffic(380);
    drain_pending();            // sender holds off until all results are in
    send_idle_pct = 64;
    recv_idle_pct = 19;
    test_random_traffic(380);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(420);
    drain_pending();
    repeat (4 * Depth + 8) @(posedge clk);
    if (fail_count == 0 && pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

### files.f
src/krq_pkg.sv
src/keyed_response_queue.sv
tb/tb_top.sv
